FILE: hdl/rau_pkg.sv
// ---------------------------------------------------------------------------
// rau_pkg
// Shared constants, types and codes for the rational arithmetic unit.
// ---------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int NUM_OUT_WIDTH     = 33;
    localparam int DEN_OUT_WIDTH     = 31;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_OUT
    } t_state;

endpackage

FILE: hdl/rau_if.sv
// ---------------------------------------------------------------------------
// rau_in_if / rau_out_if
// Valid/ready channels carrying input and result items.
// ---------------------------------------------------------------------------
interface rau_in_if #(parameter int W = 16);
    logic           valid;
    logic           ready;
    logic [1:0]     operation;
    logic signed [W-1:0] a_num;
    logic signed [W-1:0] a_den;
    logic signed [W-1:0] b_num;
    logic signed [W-1:0] b_den;
    modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic               valid;
    logic               ready;
    logic signed [32:0] result_num;
    logic [30:0]        result_den;
    logic               div_by_zero;
    modport source (output valid, result_num, result_den, div_by_zero, input ready);
    modport sink   (input valid, result_num, result_den, div_by_zero, output ready);
endinterface

FILE: hdl/rational_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies or divides two fractions, reduced by gcd.
// ---------------------------------------------------------------------------
// Each item runs serial products (3 for add and subtract, 2 otherwise), then
// Euclid steps, before its result is valid.
// Each Euclid step and the two final divisions run the serial divider.
// One item at a time: the next item is taken in idle, entered as the result
// is registered; a result left waiting stalls only the next item's output.
// Synchronous active-low reset returns the sequencer to idle, output empty.
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);
    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int DW = PW + 1;

    t_state r_state, n_state;
    t_op    r_op;
    logic   r_mstep, n_mstep;   // 0: first product pair, 1: second pair
    logic   r_dstep, n_dstep;   // add/subtract: denominator product pending

    // operand magnitudes and signs
    logic [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic         r_san, r_sad, r_sbn, r_sbd;

    logic [PW-1:0] r_p0;        // first product
    logic [DW-1:0] r_nmag, r_dmag, r_gx, r_gy, r_rn;
    logic          r_nneg, r_dneg;

    logic          r_ovalid;
    logic [32:0]   r_onum;
    logic [30:0]   r_oden;
    logic          r_oflag;

    logic          w_mul_start, w_mul_busy, w_div_start, w_div_busy;
    logic [W-1:0]  w_mx, w_my;
    logic [PW-1:0] w_prod;
    logic [DW-1:0] w_dvd, w_dvs, w_q, w_r;

    function automatic logic [W-1:0] f_mag(input logic [W-1:0] v);
        f_mag = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // multiplier operand select
    always_comb begin
        w_mx = r_an;
        w_my = r_bd;
        unique case (r_op)
            OP_ADD, OP_SUB: begin
                w_mx = r_dstep ? r_ad : (r_mstep ? r_bn : r_an);
                w_my = r_dstep ? r_bd : (r_mstep ? r_ad : r_bd);
            end
            OP_MUL: begin
                w_mx = r_mstep ? r_ad : r_an;
                w_my = r_mstep ? r_bd : r_bn;
            end
            OP_DIV: begin
                w_mx = r_mstep ? r_ad : r_an;
                w_my = r_mstep ? r_bn : r_bd;
            end
            default: ;
        endcase
    end

    rau_mul #(.W(W)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mul_start),
        .i_x(w_mx), .i_y(w_my), .o_busy(w_mul_busy), .o_prod(w_prod)
    );

    rau_div #(.DW(DW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_dividend(w_dvd), .i_divisor(w_dvs), .o_busy(w_div_busy),
        .o_quot(w_q), .o_rem(w_r)
    );

    assign i_in.ready = (r_state == ST_IDLE);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_mstep     = r_mstep;
        n_dstep     = r_dstep;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_dvd       = r_gx;
        w_dvs       = r_gy;
        unique case (r_state)
            ST_IDLE: if (i_in.valid) begin
                n_state = ST_MUL;
                n_mstep = 1'b0;
                n_dstep = 1'b0;
            end
            ST_MUL: begin
                w_mul_start = 1'b1;
                n_state     = ST_SUM;
            end
            ST_SUM: if (!w_mul_busy) begin
                if (!r_mstep) begin
                    n_mstep = 1'b1;
                    n_state = ST_MUL;
                end else if ((r_op == OP_ADD || r_op == OP_SUB) && !r_dstep) begin
                    // denominator product still to come
                    n_dstep = 1'b1;
                    n_state = ST_MUL;
                end else begin
                    n_mstep = 1'b0;
                    n_dstep = 1'b0;
                    n_state = ST_GCD;
                end
            end
            ST_GCD: begin
                // gcd in r_gx while r_gy is zero
                if (r_dmag == '0 || r_nmag == '0 || r_gy == '0) begin
                    if (r_dmag == '0 || r_nmag == '0) begin
                        n_state = ST_OUT;
                    end else begin
                        w_dvd       = r_nmag;
                        w_dvs       = r_gx;
                        w_div_start = 1'b1;
                        n_state     = ST_DIVN;
                    end
                end else if (!w_div_busy && !r_mstep) begin
                    w_div_start = 1'b1;
                    n_mstep     = 1'b1;
                end else if (!w_div_busy) begin
                    n_mstep = 1'b0;
                end
            end
            ST_DIVN: if (!w_div_busy) begin
                w_dvd       = r_dmag;
                w_dvs       = r_gx;
                w_div_start = 1'b1;
                n_state     = ST_DIVD;
            end
            ST_DIVD: if (!w_div_busy) n_state = ST_OUT;
            ST_OUT:  if (!r_ovalid || o_out.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // signed combine of the two products
    logic [DW-1:0] w_pa, w_pb, w_sum;
    logic          w_sa, w_sb, w_sneg;
    always_comb begin
        w_pa = {1'b0, r_p0};
        w_pb = {1'b0, w_prod};
        w_sa = (r_san ^ r_sbd) && (r_p0 != '0);
        w_sb = (r_sbn ^ r_sad) && (w_prod != '0);
        if (r_op == OP_SUB) w_sb = !w_sb && (w_prod != '0);
        if (w_sa == w_sb) begin
            w_sum  = w_pa + w_pb;
            w_sneg = w_sa;
        end else if (w_pa >= w_pb) begin
            w_sum  = w_pa - w_pb;
            w_sneg = w_sa;
        end else begin
            w_sum  = w_pb - w_pa;
            w_sneg = w_sb;
        end
        if (w_sum == '0) w_sneg = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mstep  <= 1'b0;
            r_dstep  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mstep  <= n_mstep;
            r_dstep  <= n_dstep;
            r_ovalid <= (r_state == ST_OUT && (!r_ovalid || o_out.ready)) ? 1'b1 :
                        (o_out.ready ? 1'b0 : r_ovalid);
        end

        if (r_state == ST_IDLE && i_in.valid) begin
            r_op  <= t_op'(i_in.operation);
            r_an  <= f_mag(i_in.a_num);  r_san <= i_in.a_num[W-1];
            r_ad  <= f_mag(i_in.a_den);  r_sad <= i_in.a_den[W-1];
            r_bn  <= f_mag(i_in.b_num);  r_sbn <= i_in.b_num[W-1];
            r_bd  <= f_mag(i_in.b_den);  r_sbd <= i_in.b_den[W-1];
        end

        // collect products, form n and d
        if (r_state == ST_SUM && !w_mul_busy) begin
            if (!r_mstep) begin
                r_p0 <= w_prod;
            end else if (r_op == OP_ADD || r_op == OP_SUB) begin
                if (!r_dstep) begin
                    r_nmag <= w_sum;
                    r_nneg <= w_sneg;
                    r_gx   <= w_sum;
                end else begin
                    r_dmag <= {1'b0, w_prod};
                    r_dneg <= r_sad ^ r_sbd;
                    r_gy   <= {1'b0, w_prod};
                end
            end else begin
                r_nmag <= {1'b0, r_p0};
                r_dmag <= {1'b0, w_prod};
                r_gx   <= {1'b0, r_p0};
                r_gy   <= {1'b0, w_prod};
                if (r_op == OP_MUL) begin
                    r_nneg <= r_san ^ r_sbn;
                    r_dneg <= r_sad ^ r_sbd;
                end else begin
                    r_nneg <= r_san ^ r_sbd;
                    r_dneg <= r_sad ^ r_sbn;
                end
            end
        end

        // Euclid step: x, y <- y, x mod y
        if (r_state == ST_GCD && r_gy != '0 && !w_div_busy && r_mstep) begin
            r_gx <= r_gy;
            r_gy <= w_r;
        end
        if (r_state == ST_DIVN && !w_div_busy) r_rn <= w_q;

        // result register
        if (r_state == ST_OUT && (!r_ovalid || o_out.ready)) begin
            if (r_dmag == '0) begin
                r_onum  <= '0;
                r_oden  <= '0;
                r_oflag <= 1'b1;
            end else if (r_nmag == '0) begin
                r_onum  <= '0;
                r_oden  <= 31'd1;
                r_oflag <= 1'b0;
            end else begin
                r_onum  <= (r_nneg ^ r_dneg) ? 33'(~r_rn + 1'b1) : 33'(r_rn);
                r_oden  <= 31'(w_q);
                r_oflag <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.result_num  = r_onum;
    assign o_out.result_den  = r_oden;
    assign o_out.div_by_zero = r_oflag;

    // checks
    a_busy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_div_busy)
        else $error("divider busy while idle");
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.div_by_zero) |-> (o_out.result_den == '0))
        else $error("flagged result with denominator");
    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.div_by_zero) |-> (o_out.result_den != '0))
        else $error("zero denominator without flag");
endmodule

FILE: hdl/rau_mul.sv
// ---------------------------------------------------------------------------
// rau_mul
// Bit-serial unsigned multiplier: one multiplier bit per cycle, shift-add.
// ---------------------------------------------------------------------------
module rau_mul
    import rau_pkg::*;
#(
    parameter int W = OPERAND_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_x,
    input  logic [W-1:0]   i_y,
    output logic           o_busy,
    output logic [2*W-1:0] o_prod
);
    localparam int CW = $clog2(W + 1);

    logic [2*W-1:0] r_acc, n_acc;
    logic [2*W-1:0] r_mcand, n_mcand;
    logic [W-1:0]   r_mplier, n_mplier;
    logic [CW-1:0]  r_cnt, n_cnt;

    // shift-add step
    always_comb begin
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_cnt    = r_cnt;
        if (i_start) begin
            n_acc    = '0;
            n_mcand  = {{W{1'b0}}, i_x};
            n_mplier = i_y;
            n_cnt    = CW'(W);
        end else if (r_cnt != '0) begin
            if (r_mplier[0]) n_acc = r_acc + r_mcand;
            n_mcand  = {r_mcand[2*W-2:0], 1'b0};
            n_mplier = {1'b0, r_mplier[W-1:1]};
            n_cnt    = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

    assign o_busy = (r_cnt != '0);
    assign o_prod = r_acc;
endmodule

FILE: hdl/rau_div.sv
// ---------------------------------------------------------------------------
// rau_div
// Restoring bit-serial divider: one quotient bit per cycle, gives q and r.
// ---------------------------------------------------------------------------
module rau_div
    import rau_pkg::*;
#(
    parameter int DW = 2 * OPERAND_WIDTH_DEF + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quot,
    output logic [DW-1:0] o_rem
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_q, n_q;
    logic [DW-1:0] r_r, n_r;
    logic [DW-1:0] r_d, n_d;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW:0]   w_trial;

    // one restoring step
    always_comb begin
        n_q     = r_q;
        n_r     = r_r;
        n_d     = r_d;
        n_cnt   = r_cnt;
        w_trial = {r_r, r_q[DW-1]} - {1'b0, r_d};
        if (i_start) begin
            n_q   = i_dividend;
            n_r   = '0;
            n_d   = i_divisor;
            n_cnt = CW'(DW);
        end else if (r_cnt != '0) begin
            if (!w_trial[DW]) begin
                n_r = w_trial[DW-1:0];
                n_q = {r_q[DW-2:0], 1'b1};
            end else begin
                n_r = {r_r[DW-2:0], r_q[DW-1]};
                n_q = {r_q[DW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        r_d <= n_d;
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule
